// File: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold on every clock edge outside reset.
`define CHK_HOLDS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("rgbansi check failed");

// When the antecedent holds, the consequent must hold on the same edge.
`define CHK_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rgbansi check failed");

// When the antecedent holds, the consequent must hold on the next edge.
`define CHK_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("rgbansi check failed");

`endif

// File: sv/rgbansi_pkg.sv
// ---------------------------------------------------------------------------
// rgbansi_pkg
// Types, constants and palette tables of the RGB to ANSI shaded color block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rgbansi_pkg;

    localparam int GRID_STEPS_DEF = 32;
    localparam int Q_ONE          = 65536;

    localparam int NUM_LVL = 5;
    localparam int NUM_PAL = 16;
    localparam int COORD_W = 17;
    localparam int SQ_W    = 33;
    localparam int DIST_W  = 34;
    localparam int IDX_W   = 4;
    localparam int LVL_W   = 3;
    localparam int DIFF_W  = 18;
    localparam int PROD_W  = 36;
    localparam int SUM_W   = 38;

    localparam int MID_DEPTH = 8;
    localparam int OUT_DEPTH = 8;

    // Coordinate level codes of the palette points.
    localparam logic [LVL_W-1:0] LVL_ZERO = 3'd0;
    localparam logic [LVL_W-1:0] LVL_LO   = 3'd1;
    localparam logic [LVL_W-1:0] LVL_HALF = 3'd2;
    localparam logic [LVL_W-1:0] LVL_HI   = 3'd3;
    localparam logic [LVL_W-1:0] LVL_ONE  = 3'd4;

    localparam logic [LVL_W-1:0] PAL_LR [NUM_PAL] = '{
        LVL_ZERO, LVL_HALF, LVL_ZERO, LVL_ZERO, LVL_HALF, LVL_HALF, LVL_ZERO, LVL_HI,
        LVL_LO, LVL_ONE, LVL_ZERO, LVL_ZERO, LVL_ONE, LVL_ONE, LVL_ZERO, LVL_ONE};
    localparam logic [LVL_W-1:0] PAL_LG [NUM_PAL] = '{
        LVL_ZERO, LVL_ZERO, LVL_HALF, LVL_ZERO, LVL_ZERO, LVL_HALF, LVL_HALF, LVL_HI,
        LVL_LO, LVL_ZERO, LVL_ONE, LVL_ZERO, LVL_ZERO, LVL_ONE, LVL_ONE, LVL_ONE};
    localparam logic [LVL_W-1:0] PAL_LB [NUM_PAL] = '{
        LVL_ZERO, LVL_ZERO, LVL_ZERO, LVL_HALF, LVL_HALF, LVL_ZERO, LVL_HALF, LVL_HI,
        LVL_LO, LVL_ZERO, LVL_ZERO, LVL_ONE, LVL_ONE, LVL_ZERO, LVL_ONE, LVL_ONE};
    localparam logic [3:0] PAL_C [NUM_PAL] = '{
        4'd0, 4'd1, 4'd2, 4'd4, 4'd5, 4'd3, 4'd6, 4'd7,
        4'd8, 4'd9, 4'd10, 4'd12, 4'd13, 4'd11, 4'd14, 4'd15};

    localparam logic [6:0] FG_NORMAL = 7'd30;
    localparam logic [6:0] FG_BRIGHT = 7'd90;
    localparam logic [6:0] BG_NORMAL = 7'd40;
    localparam logic [6:0] BG_BRIGHT = 7'd100;
    localparam logic [6:0] FG_FULL   = 7'd30;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [6:0] fg_code;
        logic [6:0] bg_code;
        logic [1:0] shade;
    } t_result;

    // Snapped pixel and the ordered pair of palette points.
    typedef struct packed {
        logic [COORD_W-1:0] c_r;
        logic [COORD_W-1:0] c_g;
        logic [COORD_W-1:0] c_b;
        logic [IDX_W-1:0]   m1;
        logic [IDX_W-1:0]   m2;
    } t_pair;

    function automatic logic [COORD_W-1:0] lvl_coord(logic [LVL_W-1:0] code);
        logic [COORD_W-1:0] v;
        unique case (code)
            LVL_ZERO: v = 17'd0;
            LVL_LO:   v = 17'd21823;
            LVL_HALF: v = 17'd32768;
            LVL_HI:   v = 17'd43647;
            LVL_ONE:  v = 17'd65536;
            default:  v = 17'd0;
        endcase
        return v;
    endfunction

    function automatic logic [6:0] fg_of(logic [3:0] c);
        return (c[3] ? FG_BRIGHT : FG_NORMAL) + {4'd0, c[2:0]};
    endfunction

    function automatic logic [6:0] bg_of(logic [3:0] c);
        return (c[3] ? BG_BRIGHT : BG_NORMAL) + {4'd0, c[2:0]};
    endfunction

endpackage

`default_nettype wire

// File: sv/rgbansi_fifo.sv
// ---------------------------------------------------------------------------
// rgbansi_fifo
// Small register queue with show-ahead read; the head is valid while not empty.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgbansi_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_empty
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW:0]      r_wr;
    logic [AW:0]      r_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + (AW+1)'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + (AW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr[AW-1:0]] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd[AW-1:0]];
    assign o_empty = (r_wr == r_rd);

endmodule

`default_nettype wire

// File: sv/rgbansi_front.sv
// ---------------------------------------------------------------------------
// rgbansi_front
// Snaps the pixel to the grid, measures the distance to every palette point
// and picks the two nearest, ordered by their distance from black.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgbansi_front #(
    parameter int GRID_STEPS = rgbansi_pkg::GRID_STEPS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  rgbansi_pkg::t_pixel      i_pixel,
    output logic                     o_valid,
    output rgbansi_pkg::t_pair       o_pair
);

    import rgbansi_pkg::*;

    localparam int Div = (GRID_STEPS > 1) ? GRID_STEPS - 1 : 1;

    typedef struct packed {
        logic [DIST_W-1:0] d1;
        logic [IDX_W-1:0]  i1;
        logic [DIST_W-1:0] d2;
        logic [IDX_W-1:0]  i2;
    } t_top2;

    // Keeps the best two of both sides; every index on side b is later than
    // those on side a, so b wins a tie.
    function automatic t_top2 merge(t_top2 a, t_top2 b);
        t_top2 m;
        if (b.d1 <= a.d1) begin
            m.d1 = b.d1;
            m.i1 = b.i1;
            if (b.d2 <= a.d1) begin
                m.d2 = b.d2;
                m.i2 = b.i2;
            end else begin
                m.d2 = a.d1;
                m.i2 = a.i1;
            end
        end else begin
            m.d1 = a.d1;
            m.i1 = a.i1;
            if (b.d1 <= a.d2) begin
                m.d2 = b.d1;
                m.i2 = b.i1;
            end else begin
                m.d2 = a.d2;
                m.i2 = a.i2;
            end
        end
        return m;
    endfunction

    // Constant tables: snapped coordinate and squared distance to each level.
    logic [COORD_W-1:0] w_coord_lut [256];
    logic [SQ_W-1:0]    w_sq_lut    [256][NUM_LVL];
    logic [DIST_W-1:0]  w_norm      [NUM_PAL];

    for (genvar gv = 0; gv < 256; gv++) begin : g_snap
        localparam int IdxRaw = (gv * GRID_STEPS) / 255;
        localparam int Idx    = (IdxRaw > Div) ? Div : IdxRaw;
        localparam int Coord  = (Idx * Q_ONE + Div / 2) / Div;
        assign w_coord_lut[gv] = COORD_W'(Coord);
        for (genvar gl = 0; gl < NUM_LVL; gl++) begin : g_lvl
            localparam longint Diff = longint'(Coord) - longint'(lvl_coord(LVL_W'(gl)));
            assign w_sq_lut[gv][gl] = SQ_W'(Diff * Diff);
        end
    end

    for (genvar gk = 0; gk < NUM_PAL; gk++) begin : g_norm
        localparam longint Nr = longint'(lvl_coord(PAL_LR[gk]));
        localparam longint Ng = longint'(lvl_coord(PAL_LG[gk]));
        localparam longint Nb = longint'(lvl_coord(PAL_LB[gk]));
        assign w_norm[gk] = DIST_W'(Nr * Nr + Ng * Ng + Nb * Nb);
    end

    logic [7:0] w_chan [3];
    assign w_chan[0] = i_pixel.red;
    assign w_chan[1] = i_pixel.green;
    assign w_chan[2] = i_pixel.blue;

    // Stage 0: table lookups.
    logic               r_v0;
    logic [COORD_W-1:0] r_c0  [3];
    logic [SQ_W-1:0]    r_sq0 [3][NUM_LVL];
    // Stage 1: distances.
    logic               r_v1;
    logic [COORD_W-1:0] r_c1  [3];
    logic [DIST_W-1:0]  r_dist1 [NUM_PAL];
    // Stage 2 and 3: selection tree.
    logic               r_v2;
    logic [COORD_W-1:0] r_c2  [3];
    t_top2              r_n2  [4];
    logic               r_v3;
    logic [COORD_W-1:0] r_c3  [3];
    t_top2              r_n3;
    // Stage 4: ordered pair.
    logic               r_v4;
    t_pair              r_pair4;

    t_top2 w_leaf [NUM_PAL];
    t_top2 w_n1   [8];
    t_top2 w_n2   [4];
    t_top2 w_n3   [2];
    t_top2 w_n4;
    logic  w_swap;

    always_comb begin
        for (int k = 0; k < NUM_PAL; k++) begin
            w_leaf[k].d1 = r_dist1[k];
            w_leaf[k].i1 = IDX_W'(k);
            w_leaf[k].d2 = '1;
            w_leaf[k].i2 = IDX_W'(k);
        end
        for (int k = 0; k < 8; k++) begin
            w_n1[k] = merge(w_leaf[2*k], w_leaf[2*k+1]);
        end
        for (int k = 0; k < 4; k++) begin
            w_n2[k] = merge(w_n1[2*k], w_n1[2*k+1]);
        end
        for (int k = 0; k < 2; k++) begin
            w_n3[k] = merge(r_n2[2*k], r_n2[2*k+1]);
        end
        w_n4 = merge(w_n3[0], w_n3[1]);
    end

    assign w_swap = w_norm[r_n3.i2] < w_norm[r_n3.i1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v0 <= i_valid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int ch = 0; ch < 3; ch++) begin
            r_c0[ch] <= w_coord_lut[w_chan[ch]];
            for (int l = 0; l < NUM_LVL; l++) begin
                r_sq0[ch][l] <= w_sq_lut[w_chan[ch]][l];
            end
            r_c1[ch] <= r_c0[ch];
            r_c2[ch] <= r_c1[ch];
            r_c3[ch] <= r_c2[ch];
        end
        for (int k = 0; k < NUM_PAL; k++) begin
            r_dist1[k] <= DIST_W'(r_sq0[0][PAL_LR[k]]) + DIST_W'(r_sq0[1][PAL_LG[k]])
                        + DIST_W'(r_sq0[2][PAL_LB[k]]);
        end
        r_n2 <= w_n2;
        r_n3 <= w_n4;
        r_pair4.c_r <= r_c3[0];
        r_pair4.c_g <= r_c3[1];
        r_pair4.c_b <= r_c3[2];
        r_pair4.m1  <= w_swap ? r_n3.i2 : r_n3.i1;
        r_pair4.m2  <= w_swap ? r_n3.i1 : r_n3.i2;
    end

    assign o_valid = r_v4;
    assign o_pair  = r_pair4;

endmodule

`default_nettype wire

// File: sv/rgbansi_back.sv
// ---------------------------------------------------------------------------
// rgbansi_back
// Projects the snapped pixel onto the segment between the two palette points
// and turns the blend weight into the color codes and the shade.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgbansi_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  rgbansi_pkg::t_pair     i_pair,
    output logic                   o_valid,
    output rgbansi_pkg::t_result   o_result
);

    import rgbansi_pkg::*;

    localparam int CMP_W = SUM_W + 3;

    logic [COORD_W-1:0] w_c  [3];
    logic [COORD_W-1:0] w_p1 [3];
    logic [COORD_W-1:0] w_p2 [3];

    assign w_c[0]  = i_pair.c_r;
    assign w_c[1]  = i_pair.c_g;
    assign w_c[2]  = i_pair.c_b;
    assign w_p1[0] = lvl_coord(PAL_LR[i_pair.m1]);
    assign w_p1[1] = lvl_coord(PAL_LG[i_pair.m1]);
    assign w_p1[2] = lvl_coord(PAL_LB[i_pair.m1]);
    assign w_p2[0] = lvl_coord(PAL_LR[i_pair.m2]);
    assign w_p2[1] = lvl_coord(PAL_LG[i_pair.m2]);
    assign w_p2[2] = lvl_coord(PAL_LB[i_pair.m2]);

    logic                     r_v0, r_v1, r_v2, r_v3;
    logic signed [DIFF_W-1:0] r_a0 [3];
    logic signed [DIFF_W-1:0] r_b0 [3];
    logic [IDX_W-1:0]         r_m1_0, r_m2_0, r_m1_1, r_m2_1, r_m1_2, r_m2_2;
    logic signed [PROD_W-1:0] r_pn1 [3];
    logic signed [PROD_W-1:0] r_pd1 [3];
    logic signed [SUM_W-1:0]  r_num2;
    logic signed [SUM_W-1:0]  r_den2;
    t_result                  r_res3;

    // x >= k/4 - 1/8 is the same as 8*num >= (2k-1)*den, so no divide is needed.
    logic signed [CMP_W-1:0] w_n8, w_d1, w_d3, w_d5, w_d7;
    logic [1:0]              w_shade;
    logic                    w_full;
    t_result                 w_res;

    always_comb begin
        w_n8  = CMP_W'(r_num2) <<< 3;
        w_d1  = CMP_W'(r_den2);
        w_d3  = w_d1 + (w_d1 <<< 1);
        w_d5  = w_d1 + (w_d1 <<< 2);
        w_d7  = (w_d1 <<< 3) - w_d1;
        w_full = w_n8 >= w_d7;
        priority if (w_n8 >= w_d5) begin
            w_shade = 2'd3;
        end else if (w_n8 >= w_d3) begin
            w_shade = 2'd2;
        end else if (w_n8 >= w_d1) begin
            w_shade = 2'd1;
        end else begin
            w_shade = 2'd0;
        end
        if (w_full) begin
            w_res.fg_code = FG_FULL;
            w_res.bg_code = bg_of(PAL_C[r_m2_2]);
            w_res.shade   = 2'd0;
        end else begin
            w_res.fg_code = fg_of(PAL_C[r_m2_2]);
            w_res.bg_code = bg_of(PAL_C[r_m1_2]);
            w_res.shade   = w_shade;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v0 <= i_valid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int ch = 0; ch < 3; ch++) begin
            r_a0[ch]  <= $signed({1'b0, w_c[ch]}) - $signed({1'b0, w_p1[ch]});
            r_b0[ch]  <= $signed({1'b0, w_p2[ch]}) - $signed({1'b0, w_p1[ch]});
            r_pn1[ch] <= r_a0[ch] * r_b0[ch];
            r_pd1[ch] <= r_b0[ch] * r_b0[ch];
        end
        r_m1_0 <= i_pair.m1;
        r_m2_0 <= i_pair.m2;
        r_m1_1 <= r_m1_0;
        r_m2_1 <= r_m2_0;
        r_m1_2 <= r_m1_1;
        r_m2_2 <= r_m2_1;
        r_num2 <= SUM_W'(r_pn1[0]) + SUM_W'(r_pn1[1]) + SUM_W'(r_pn1[2]);
        r_den2 <= SUM_W'(r_pd1[0]) + SUM_W'(r_pd1[1]) + SUM_W'(r_pd1[2]);
        r_res3 <= w_res;
    end

    assign o_valid  = r_v3;
    assign o_result = r_res3;

endmodule

`default_nettype wire

// File: sv/rgb_to_ansi_shaded_color_top.sv
// Path: an accepted pixel passes the front pipeline, the mid queue, the back pipeline and the out queue.
// Throughput: one pixel per cycle; the front and back pipelines both advance
// every cycle, and credit counters sized to the two 8-entry queues stop push
// only when the result side has been stalled long enough to fill them.
// Reset: synchronous, active low; clears both queues and all valid bits.
// ---------------------------------------------------------------------------
// rgb_to_ansi_shaded_color_top
// Maps an RGB pixel to an ANSI foreground, background and dither shade.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_ansi_shaded_color_top #(
    parameter int GRID_STEPS = rgbansi_pkg::GRID_STEPS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              push,
    input  rgbansi_pkg::t_pixel    i_pixel,
    output logic                   full,
    output logic                   empty,
    input  wire logic              pop,
    output rgbansi_pkg::t_result   o_result
);

    import rgbansi_pkg::*;

    localparam int MidCntW = $clog2(MID_DEPTH + 1);
    localparam int OutCntW = $clog2(OUT_DEPTH + 1);

    logic    w_accept;
    logic    w_front_valid;
    t_pair   w_front_pair;
    t_pair   w_mid_head;
    logic    w_mid_empty;
    logic    w_mid_pop;
    logic    w_back_valid;
    t_result w_back_result;
    logic    w_out_pop;

    logic [MidCntW-1:0] r_front_cnt, n_front_cnt;
    logic [OutCntW-1:0] r_back_cnt, n_back_cnt;

    assign w_accept  = push && !full;
    assign w_mid_pop = !w_mid_empty && (r_back_cnt != OutCntW'(OUT_DEPTH));
    assign w_out_pop = pop && !empty;
    assign full      = (r_front_cnt == MidCntW'(MID_DEPTH));

    // Each count covers beats in flight in a pipeline plus those in its queue.
    assign n_front_cnt = r_front_cnt + MidCntW'(w_accept) - MidCntW'(w_mid_pop);
    assign n_back_cnt  = r_back_cnt + OutCntW'(w_mid_pop) - OutCntW'(w_out_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_cnt <= '0;
            r_back_cnt  <= '0;
        end else begin
            r_front_cnt <= n_front_cnt;
            r_back_cnt  <= n_back_cnt;
        end
    end

    rgbansi_front #(
        .GRID_STEPS (GRID_STEPS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_pixel (i_pixel),
        .o_valid (w_front_valid),
        .o_pair  (w_front_pair)
    );

    rgbansi_fifo #(
        .WIDTH ($bits(t_pair)),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_valid),
        .i_data  (w_front_pair),
        .i_pop   (w_mid_pop),
        .o_data  (w_mid_head),
        .o_empty (w_mid_empty)
    );

    rgbansi_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_mid_pop),
        .i_pair   (w_mid_head),
        .o_valid  (w_back_valid),
        .o_result (w_back_result)
    );

    rgbansi_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_back_valid),
        .i_data  (w_back_result),
        .i_pop   (w_out_pop),
        .o_data  (o_result),
        .o_empty (empty)
    );

endmodule

`default_nettype wire

// File: sv/rgbansi_chk.sv
// ---------------------------------------------------------------------------
// rgbansi_chk
// Port-level checks of the RGB to ANSI shaded color block, bound to its top.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module rgbansi_chk (
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    input wire logic            full,
    input wire logic            empty,
    input rgbansi_pkg::t_result o_result
);

    logic w_fg_ok;
    logic w_bg_ok;

    assign w_fg_ok = (o_result.fg_code >= 7'd30 && o_result.fg_code <= 7'd37)
                  || (o_result.fg_code >= 7'd90 && o_result.fg_code <= 7'd97);
    assign w_bg_ok = (o_result.bg_code >= 7'd40 && o_result.bg_code <= 7'd47)
                  || (o_result.bg_code >= 7'd100 && o_result.bg_code <= 7'd107);

    `CHK_NEXT(a_reset_clears, i_clk, !i_rst_n, empty && !full)
    `CHK_IMPLY(a_fg_range, i_clk, i_rst_n, !empty, w_fg_ok)
    `CHK_IMPLY(a_bg_range, i_clk, i_rst_n, !empty, w_bg_ok)
    // The lighter color can never be black, so foreground 30 only comes from a full shade.
    `CHK_IMPLY(a_full_shade, i_clk, i_rst_n, !empty && o_result.fg_code == 7'd30, o_result.shade == 2'd0)

endmodule

bind rgb_to_ansi_shaded_color_top rgbansi_chk u_chk (.*);

`default_nettype wire

// File: sim/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Drives RGB pixels into the ANSI shaded color block through its queue-style
// handshake and checks every result beat against an in-bench color predictor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module testbench;
    import rgbansi_pkg::*;

    localparam int GRID       = GRID_STEPS_DEF;
    localparam int IDLE_LIMIT = 20000;
    localparam int LATENCY    = 10;

    // Idling phases.
    localparam int PH_NONE = 0;
    localparam int PH_SEND = 1;
    localparam int PH_RECV = 2;
    localparam int PH_BOTH = 3;

    logic    i_clk;
    logic    i_rst_n;
    logic    push;
    t_pixel  i_pixel;
    logic    full;
    logic    empty;
    logic    pop;
    t_result o_result;

    t_pixel  pixel_queue[$];
    t_result color_queue[$];
    int      phase;
    int      errors = 0;
    int      idle_cycles = 0;
    logic    hold_push;
    logic    stim_done;

    rgb_to_ansi_shaded_color_top u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .i_pixel  (i_pixel),
        .full     (full),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic longint snap_coord(logic [7:0] v);
        longint idx;
        idx = (longint'(v) * GRID) / 255;
        if (idx > GRID - 1) begin
            idx = GRID - 1;
        end
        return (idx * Q_ONE + (GRID - 1) / 2) / (GRID - 1);
    endfunction

    function automatic longint pal_dist(longint r, longint g, longint b, int k);
        longint dr;
        longint dg;
        longint db;
        dr = r - longint'(lvl_coord(PAL_LR[k]));
        dg = g - longint'(lvl_coord(PAL_LG[k]));
        db = b - longint'(lvl_coord(PAL_LB[k]));
        return dr * dr + dg * dg + db * db;
    endfunction

    function automatic t_result predict_color(t_pixel p);
        longint r, g, b, best, d, num, den, x, shade;
        longint br, bg, bb;
        int near1, near2, t;
        t_result res;
        r = snap_coord(p.red);
        g = snap_coord(p.green);
        b = snap_coord(p.blue);
        near1 = 0;
        near2 = 0;
        best = 64'h7FFF_FFFF_FFFF_FFFF;
        for (int k = 0; k < NUM_PAL; k++) begin
            d = pal_dist(r, g, b, k);
            if (d <= best) begin
                best = d;
                near1 = k;
            end
        end
        best = 64'h7FFF_FFFF_FFFF_FFFF;
        for (int k = 0; k < NUM_PAL; k++) begin
            d = pal_dist(r, g, b, k);
            if (k != near1 && d <= best) begin
                best = d;
                near2 = k;
            end
        end
        // The darker point of the pair becomes the background, unless the shade is full.
        if (pal_dist(0, 0, 0, near2) < pal_dist(0, 0, 0, near1)) begin
            t = near1;
            near1 = near2;
            near2 = t;
        end
        br = longint'(lvl_coord(PAL_LR[near2])) - longint'(lvl_coord(PAL_LR[near1]));
        bg = longint'(lvl_coord(PAL_LG[near2])) - longint'(lvl_coord(PAL_LG[near1]));
        bb = longint'(lvl_coord(PAL_LB[near2])) - longint'(lvl_coord(PAL_LB[near1]));
        num = (r - longint'(lvl_coord(PAL_LR[near1]))) * br
            + (g - longint'(lvl_coord(PAL_LG[near1]))) * bg
            + (b - longint'(lvl_coord(PAL_LB[near1]))) * bb;
        den = br * br + bg * bg + bb * bb;
        if (num <= 0 || den <= 0) begin
            x = 0;
        end else if (num >= den) begin
            x = Q_ONE;
        end else begin
            x = (num * Q_ONE) / den;
        end
        shade = (x * 4 + Q_ONE / 2) >>> 16;
        if (shade >= 4) begin
            res.fg_code = FG_FULL;
            res.bg_code = bg_of(PAL_C[near2]);
            res.shade   = 2'd0;
        end else begin
            res.fg_code = fg_of(PAL_C[near2]);
            res.bg_code = bg_of(PAL_C[near1]);
            res.shade   = shade[1:0];
        end
        return res;
    endfunction

    function automatic t_pixel make_pixel(int r, int g, int b);
        t_pixel p;
        p.red   = r[7:0];
        p.green = g[7:0];
        p.blue  = b[7:0];
        return p;
    endfunction

    function automatic void queue_pixel(t_pixel p);
        pixel_queue.insert(pixel_queue.size(), p);
    endfunction

    function automatic logic gap_now(int pct);
        return $urandom_range(99, 0) < pct;
    endfunction

    // Driver: a beat is taken when push is high and full is low.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push    <= 1'b0;
            i_pixel <= '0;
        end else begin
            if (push && !full) begin
                color_queue.insert(color_queue.size(), predict_color(i_pixel));
                void'(pixel_queue.pop_front());
            end
            if (pixel_queue.size() == 0 || hold_push) begin
                push <= 1'b0;
            end else if (!(push && !full) && push) begin
                push <= 1'b1;
            end else if ((phase == PH_SEND || phase == PH_BOTH)
                         && gap_now((phase == PH_BOTH) ? 11 : 76)) begin
                push <= 1'b0;
            end else begin
                push    <= 1'b1;
                i_pixel <= pixel_queue[0];
            end
        end
    end

    // Monitor: compares each popped beat with the oldest expected color.
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (color_queue.size() == 0) begin
                    $display("%0t: unexpected result beat %h", $time, o_result);
                    errors++;
                end else begin
                    want = color_queue.pop_front();
                    if (o_result.fg_code !== want.fg_code) begin
                        $display("%0t: fg_code expected %0d actual %0d",
                                 $time, want.fg_code, o_result.fg_code);
                        errors++;
                    end
                    if (o_result.bg_code !== want.bg_code) begin
                        $display("%0t: bg_code expected %0d actual %0d",
                                 $time, want.bg_code, o_result.bg_code);
                        errors++;
                    end
                    if (o_result.shade !== want.shade) begin
                        $display("%0t: shade expected %0d actual %0d",
                                 $time, want.shade, o_result.shade);
                        errors++;
                    end
                end
            end
            pop <= !((phase == PH_RECV || phase == PH_BOTH)
                     && gap_now((phase == PH_BOTH) ? 11 : 76));
        end
    end

    // Watchdog on cycles without any accepted beat.
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || !i_rst_n || stim_done) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (pixel_queue.size() != 0 || color_queue.size() != 0 || push) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        int levels[6];
        levels = '{0, 1, 127, 128, 254, 255};
        phase       = PH_NONE;
        hold_push   = 1'b0;
        stim_done   = 1'b0;
        i_rst_n     = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: black, white, primaries, grays and palette mid levels.
        for (int k = 0; k < 6; k++) begin
            queue_pixel(make_pixel(levels[k], levels[k], levels[k]));
        end
        queue_pixel(make_pixel(255, 0, 0));
        queue_pixel(make_pixel(0, 255, 0));
        queue_pixel(make_pixel(0, 0, 255));
        queue_pixel(make_pixel(255, 255, 0));
        queue_pixel(make_pixel(0, 255, 255));
        queue_pixel(make_pixel(255, 0, 255));
        queue_pixel(make_pixel(85, 85, 85));
        queue_pixel(make_pixel(170, 170, 170));
        queue_pixel(make_pixel(128, 0, 0));
        queue_pixel(make_pixel(64, 0, 0));
        queue_pixel(make_pixel(192, 0, 0));
        queue_pixel(make_pixel(255, 128, 0));
        queue_pixel(make_pixel(96, 96, 96));
        queue_pixel(make_pixel(200, 40, 220));
        wait_drained();

        // Hold off the sender until the result side has gone quiet.
        hold_push = 1'b1;
        repeat (LATENCY + 2) @(posedge i_clk);
        hold_push = 1'b0;

        for (int ph = PH_NONE; ph <= PH_BOTH; ph++) begin
            phase = ph;
            for (int n = 0; n < 260; n++) begin
                queue_pixel(make_pixel($urandom_range(255, 0),
                    $urandom_range(255, 0), $urandom_range(255, 0)));
            end
            wait_drained();
        end

        phase = PH_NONE;
        stim_done = 1'b1;
        repeat (LATENCY * 4) @(posedge i_clk);
        if (errors == 0 && color_queue.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

`default_nettype wire

// File: files.f
+incdir+sv
sv/rgbansi_pkg.sv
sv/rgbansi_fifo.sv
sv/rgbansi_front.sv
sv/rgbansi_back.sv
sv/rgb_to_ansi_shaded_color_top.sv
sv/rgbansi_chk.sv
sim/testbench.sv
